>>> sv/reachability_matrix_closure_assert.svh
// Assertion macros for the reachability matrix closure block.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef REACHABILITY_MATRIX_CLOSURE_ASSERT_SVH
`define REACHABILITY_MATRIX_CLOSURE_ASSERT_SVH

`ifndef SYNTH

// Condition holds in the same cycle as the trigger.
`define RMC_ASSERT_NOW(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Condition holds in the cycle after the trigger.
`define RMC_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`else

`define RMC_ASSERT_NOW(label, trig, cond, msg)
`define RMC_ASSERT_NEXT(label, trig, cond, msg)

`endif

`endif

>>> sv/rmc_pkg.sv
package rmc_pkg;

	localparam int MAX_NODES = 32;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);

	typedef logic [MAX_NODES-1:0] row_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	// operation codes of the input beat
	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_LINK   = 3'd1,
		OP_UNLINK = 3'd2,
		OP_PAIR   = 3'd3,
		OP_ROW    = 3'd4,
		OP_FILL   = 3'd5
	} op_t;

	// commands to the matrix store
	typedef enum logic [2:0] {
		MC_NONE,
		MC_ADD,
		MC_SET,
		MC_CLEAR,
		MC_FILL,
		MC_PIVOT
	} mcmd_op_t;

	typedef struct packed {
		mcmd_op_t op;
		idx_t     row;
		idx_t     col;
		cnt_t     cnt;
	} mcmd_t;

	// ones in every column below cnt
	function automatic row_t low_mask(input cnt_t cnt);
		row_t m;
		for (int j = 0; j < MAX_NODES; j++) begin
			m[j] = (CNT_W'(j) < cnt);
		end
		return m;
	endfunction

endpackage

>>> sv/rmc_matrix.sv
module rmc_matrix
	import rmc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  mcmd_t cmd,
	input  idx_t  rd_addr,
	output row_t  rd_row
);

	row_t rows_q [MAX_NODES];
	row_t col_bit;
	row_t fill_row;

	// single read port, shared by queries and the pivot broadcast
	assign rd_row   = rows_q[rd_addr];
	assign col_bit  = row_t'(1) << cmd.col;
	assign fill_row = low_mask(cmd.cnt);

	// update every row in parallel; a pivot ORs the pivot row into each row that reaches it
	for (genvar i = 0; i < MAX_NODES; i++) begin : g_row
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rows_q[i] <= '0;
			end else begin
				case (cmd.op)
					MC_ADD: begin
						if (idx_t'(i) == cmd.col) rows_q[i] <= col_bit;
						else rows_q[i] <= rows_q[i] & ~col_bit;
					end
					MC_SET: begin
						if (idx_t'(i) == cmd.row) rows_q[i] <= rows_q[i] | col_bit;
					end
					MC_CLEAR: begin
						if (idx_t'(i) == cmd.row) rows_q[i] <= rows_q[i] & ~col_bit;
					end
					MC_FILL: begin
						rows_q[i] <= (CNT_W'(i) < cmd.cnt) ? fill_row : '0;
					end
					MC_PIVOT: begin
						if (rows_q[i][cmd.col]) rows_q[i] <= rows_q[i] | rd_row;
					end
					default: begin
						rows_q[i] <= rows_q[i];
					end
				endcase
			end
		end
	end

endmodule

>>> sv/reachability_matrix_closure.sv
// Channel | Handshake            | Payload
// --------+----------------------+-----------------------------------------
// in      | in_valid / in_stall  | op, node_from, node_to, new_count
// out     | out_valid / out_stall| ok, reaches, row_mask, node_count
//
// Add, unlink, queries, fill and rejected beats: result registered in the
// cycle after the input beat. An accepted link runs one Warshall pivot per
// cycle for each node in use, through the shared read port of the matrix.
// No input is taken during closure or while an unread result is stalled.
// Reset clears the matrix and the node count at once.
module reachability_matrix_closure
	import rmc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           op,
	input  logic [IDX_W-1:0]     node_from,
	input  logic [IDX_W-1:0]     node_to,
	input  logic [CNT_W-1:0]     new_count,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 ok,
	output logic                 reaches,
	output logic [MAX_NODES-1:0] row_mask,
	output logic [CNT_W-1:0]     node_count
);

	`include "reachability_matrix_closure_assert.svh"

	typedef enum logic {ST_IDLE, ST_CLOSE} state_t;

	state_t  state_q;
	cnt_t    n_q;
	idx_t    k_q;
	logic    out_valid_q;
	logic    ok_q;
	logic    reaches_q;
	row_t    row_mask_q;
	cnt_t    node_count_q;

	logic    accept;
	logic    out_free;
	logic    src_ok;
	logic    dst_ok;
	logic    res_ok;
	logic    res_reaches;
	row_t    res_row;
	cnt_t    res_count;
	logic    last_pivot;
	logic    start_close;
	logic    load_res;
	mcmd_t   cmd;
	idx_t    rd_addr;
	row_t    rd_row;

	rmc_matrix u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.rd_row  (rd_row)
	);

	// take a beat only when idle and the result register frees this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;

	assign src_ok     = {1'b0, node_from} < n_q;
	assign dst_ok     = {1'b0, node_to} < n_q;
	assign last_pivot = ({1'b0, k_q} + CNT_W'(1)) == n_q;
	assign rd_addr    = (state_q == ST_CLOSE) ? k_q : node_from;

	// an accepted in-range link goes to closure; every other accepted beat loads a result
	assign start_close = accept && (op == OP_LINK) && res_ok;
	assign load_res    = accept && !start_close;

	// decode the beat into a result and a matrix command
	always_comb begin
		res_ok      = 1'b0;
		res_reaches = 1'b0;
		res_row     = '0;
		res_count   = n_q;
		cmd.op      = MC_NONE;
		cmd.row     = node_from;
		cmd.col     = node_to;
		cmd.cnt     = new_count;
		if (state_q == ST_CLOSE) begin
			cmd.op  = MC_PIVOT;
			cmd.col = k_q;
		end else if (accept) begin
			case (op)
				OP_ADD: begin
					if (n_q < CNT_W'(MAX_NODES)) begin
						res_ok    = 1'b1;
						res_count = n_q + CNT_W'(1);
						cmd.op    = MC_ADD;
						cmd.col   = n_q[IDX_W-1:0];
					end
				end
				OP_LINK: begin
					if (src_ok && dst_ok) begin
						res_ok = 1'b1;
						cmd.op = MC_SET;
					end
				end
				OP_UNLINK: begin
					if (src_ok && dst_ok) begin
						res_ok = 1'b1;
						cmd.op = MC_CLEAR;
					end
				end
				OP_PAIR: begin
					if (src_ok && dst_ok) begin
						res_ok      = 1'b1;
						res_reaches = rd_row[node_to];
					end
				end
				OP_ROW: begin
					if (src_ok) begin
						res_ok  = 1'b1;
						res_row = rd_row & low_mask(n_q);
					end
				end
				OP_FILL: begin
					if (new_count >= n_q && new_count <= CNT_W'(MAX_NODES)) begin
						res_ok    = 1'b1;
						res_count = new_count;
						cmd.op    = MC_FILL;
					end
				end
				default: begin
					res_ok = 1'b0;
				end
			endcase
		end
	end

	// sequencer, node count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			n_q          <= '0;
			k_q          <= '0;
			out_valid_q  <= 1'b0;
			ok_q         <= 1'b0;
			reaches_q    <= 1'b0;
			row_mask_q   <= '0;
			node_count_q <= '0;
		end else begin
			// drop the result once taken, unless a new one loads in its place
			if (out_valid_q && !out_stall && !load_res) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						n_q <= res_count;
						k_q <= '0;
						if (start_close) begin
							state_q <= ST_CLOSE;
						end else begin
							out_valid_q  <= 1'b1;
							ok_q         <= res_ok;
							reaches_q    <= res_reaches;
							row_mask_q   <= res_row;
							node_count_q <= res_count;
						end
					end
				end
				ST_CLOSE: begin
					// advance the pivot; emit the link result after the last one
					k_q <= k_q + IDX_W'(1);
					if (last_pivot) begin
						state_q      <= ST_IDLE;
						out_valid_q  <= 1'b1;
						ok_q         <= 1'b1;
						reaches_q    <= 1'b0;
						row_mask_q   <= '0;
						node_count_q <= n_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign reaches    = reaches_q;
	assign row_mask   = row_mask_q;
	assign node_count = node_count_q;

	`RMC_ASSERT_NOW(a_count_cap, 1'b1, n_q <= CNT_W'(MAX_NODES), "node count past capacity")
	`RMC_ASSERT_NOW(a_close_out_empty, state_q == ST_CLOSE, !out_valid_q, "result during closure")
	`RMC_ASSERT_NOW(a_pivot_range, state_q == ST_CLOSE, {1'b0, k_q} < n_q, "pivot past node count")
	`RMC_ASSERT_NEXT(a_link_closes, start_close, state_q == ST_CLOSE, "link did not start closure")
	`RMC_ASSERT_NEXT(a_count_held, state_q == ST_CLOSE, $stable(n_q), "node count moved in closure")

endmodule

>>> sim/tb_top.sv
module tb_top;
	import rmc_pkg::*;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int QUIET_LIMIT     = 5000;
	localparam int DRAIN_CYCLES    = 2 * MAX_NODES + 8;
	localparam int ITEMS_PER_PHASE = 320;

	// op codes the block does not define
	localparam logic [2:0] OP_UNDEF_A = 3'd6;
	localparam logic [2:0] OP_UNDEF_B = 3'd7;

	typedef struct packed {
		logic ok;
		logic reaches;
		row_t row_mask;
		cnt_t node_count;
	} answer_t;

	// Mirror of the reachability matrix and the queue of answers it predicts
	class reach_scoreboard;
		row_t        reach_tbl [MAX_NODES];
		int unsigned live;
		answer_t     awaited_answers [$];
		int unsigned beats_by_op [8];
		int unsigned rejected;
		int unsigned answers_checked;
		int unsigned mismatches;

		function new();
			foreach (reach_tbl[i]) reach_tbl[i] = '0;
			foreach (beats_by_op[i]) beats_by_op[i] = 0;
			live            = 0;
			rejected        = 0;
			answers_checked = 0;
			mismatches      = 0;
		endfunction

		function row_t ones_below(int unsigned n);
			logic [MAX_NODES:0] wide;
			wide    = '0;
			wide[n] = 1'b1;
			wide    = wide - 1'b1;
			return wide[MAX_NODES-1:0];
		endfunction

		// Warshall: one pivot at a time over every live row
		function void close_paths();
			for (int k = 0; k < live; k++)
				for (int i = 0; i < live; i++)
					if (reach_tbl[i][k])
						reach_tbl[i] |= reach_tbl[k];
		endfunction

		// apply one accepted beat to the mirror and queue its answer
		function void note_beat(logic [2:0] o, idx_t f, idx_t t, cnt_t c);
			answer_t a;
			logic    from_in;
			logic    to_in;
			a       = '0;
			from_in = (f < live);
			to_in   = (t < live);
			case (o)
			OP_ADD: begin
				if (live < MAX_NODES) begin
					for (int i = 0; i < live; i++)
						reach_tbl[i][live] = 1'b0;
					reach_tbl[live]       = '0;
					reach_tbl[live][live] = 1'b1;
					live++;
					a.ok = 1'b1;
				end
			end
			OP_LINK: begin
				if (from_in && to_in) begin
					reach_tbl[f][t] = 1'b1;
					close_paths();
					a.ok = 1'b1;
				end
			end
			OP_UNLINK: begin
				if (from_in && to_in) begin
					reach_tbl[f][t] = 1'b0;
					a.ok = 1'b1;
				end
			end
			OP_PAIR: begin
				if (from_in && to_in) begin
					a.reaches = reach_tbl[f][t];
					a.ok      = 1'b1;
				end
			end
			OP_ROW: begin
				if (from_in) begin
					a.row_mask = reach_tbl[f] & ones_below(live);
					a.ok       = 1'b1;
				end
			end
			OP_FILL: begin
				if (c >= live && c <= MAX_NODES) begin
					live = c;
					for (int i = 0; i < MAX_NODES; i++)
						reach_tbl[i] = (i < c) ? ones_below(c) : '0;
					a.ok = 1'b1;
				end
			end
			default: ;
			endcase
			a.node_count = cnt_t'(live);
			beats_by_op[o]++;
			if (!a.ok)
				rejected++;
			awaited_answers.insert(awaited_answers.size(), a);
		endfunction

		// compare a result beat with the oldest queued answer
		function void check_answer(logic g_ok, logic g_reaches, row_t g_row, cnt_t g_cnt);
			answer_t e;
			if (awaited_answers.size() == 0) begin
				$error("result beat with no operation outstanding");
				mismatches++;
				return;
			end
			e = awaited_answers.pop_front();
			answers_checked++;
			if (g_ok !== e.ok) begin
				$error("ok: expected %0b, got %0b", e.ok, g_ok);
				mismatches++;
			end
			if (g_reaches !== e.reaches) begin
				$error("reaches: expected %0b, got %0b", e.reaches, g_reaches);
				mismatches++;
			end
			if (g_row !== e.row_mask) begin
				$error("row_mask: expected %h, got %h", e.row_mask, g_row);
				mismatches++;
			end
			if (g_cnt !== e.node_count) begin
				$error("node_count: expected %0d, got %0d", e.node_count, g_cnt);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return awaited_answers.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] op;
	idx_t       node_from;
	idx_t       node_to;
	cnt_t       new_count;
	logic       out_valid;
	logic       out_stall;
	logic       ok;
	logic       reaches;
	row_t       row_mask;
	cnt_t       node_count;

	int unsigned     send_idle_pct = 0;
	int unsigned     stall_pct     = 0;
	bit              hold_off_req  = 1'b0;
	int unsigned     quiet_cycles  = 0;
	int unsigned     plan_nodes    = 0;
	reach_scoreboard reach_check;

	reachability_matrix_closure uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.node_from  (node_from),
		.node_to    (node_to),
		.new_count  (new_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ok         (ok),
		.reaches    (reaches),
		.row_mask   (row_mask),
		.node_count (node_count)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watch both channels: note input beats, check result beats, time out when quiet
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				reach_check.note_beat(op, node_from, node_to, new_count);
			if (out_valid && !out_stall)
				reach_check.check_answer(ok, reaches, row_mask, node_count);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL reachability_matrix_closure");
				$finish;
			end
		end
	end

	// Result side: random stall, or a long hold-off when asked
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Offer one beat, idling first at random, and return once it is taken
	task automatic send_beat(input logic [2:0] o, input idx_t f, input idx_t t, input cnt_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= o;
		node_from <= f;
		node_to   <= t;
		new_count <= c;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		// track the node count so that later indices can be kept in range
		case (o)
		OP_ADD: begin
			if (plan_nodes < MAX_NODES)
				plan_nodes++;
		end
		OP_FILL: begin
			if (c >= plan_nodes && c <= MAX_NODES)
				plan_nodes = c;
		end
		default: ;
		endcase
	endtask

	// Mostly in-range graph edits and queries, with some malformed beats
	task automatic random_beat();
		int unsigned pick;
		int unsigned grow_to;
		logic [2:0]  o;
		idx_t        f;
		idx_t        t;
		cnt_t        c;
		pick = $urandom_range(99);
		o    = 3'($urandom_range(5));
		f    = idx_t'($urandom);
		t    = idx_t'($urandom);
		c    = cnt_t'($urandom);
		if (pick < 2) begin
			o = OP_ADD;
		end else if (pick < 3) begin
			grow_to = plan_nodes + $urandom_range(2);
			o = OP_FILL;
			c = cnt_t'((grow_to > MAX_NODES) ? MAX_NODES : grow_to);
		end else if (pick < 90 && plan_nodes > 0) begin
			pick = $urandom_range(99);
			if (pick < 30)
				o = OP_LINK;
			else if (pick < 60)
				o = OP_UNLINK;
			else if (pick < 85)
				o = OP_PAIR;
			else
				o = OP_ROW;
			f = idx_t'($urandom_range(plan_nodes - 1));
			t = idx_t'($urandom_range(plan_nodes - 1));
		end else begin
			case ($urandom_range(3))
			0: o = $urandom_range(1) ? OP_UNDEF_A : OP_UNDEF_B;
			1: begin
				// push one index past the live nodes
				if (plan_nodes < MAX_NODES) begin
					if ($urandom_range(1) || o == OP_ROW)
						f = idx_t'($urandom_range(MAX_NODES - 1, plan_nodes));
					else
						t = idx_t'($urandom_range(MAX_NODES - 1, plan_nodes));
					if (o == OP_ADD || o == OP_FILL)
						o = OP_PAIR;
				end else begin
					o = OP_UNDEF_A;
				end
			end
			2: begin
				o = OP_FILL;
				if (plan_nodes > 0)
					c = cnt_t'($urandom_range(plan_nodes - 1));
				else
					c = cnt_t'($urandom_range(63, MAX_NODES + 1));
			end
			default: begin
				o = OP_FILL;
				c = cnt_t'($urandom_range(63, MAX_NODES + 1));
			end
			endcase
		end
		send_beat(o, f, t, c);
	endtask

	initial begin
		int unsigned idle_plan [4];
		int unsigned stall_plan [4];
		idle_plan  = '{0, 81, 0, 18};
		stall_plan = '{0, 0, 81, 18};
		reach_check = new();
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		op        <= OP_ADD;
		node_from <= '0;
		node_to   <= '0;
		new_count <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty graph: every index is out of range
		send_beat(OP_ROW, 5'd0, 5'd0, 6'd0);
		send_beat(OP_PAIR, 5'd0, 5'd0, 6'd0);
		send_beat(OP_LINK, 5'd0, 5'd0, 6'd0);
		send_beat(OP_UNLINK, 5'd0, 5'd0, 6'd0);
		send_beat(OP_UNDEF_A, 5'd31, 5'd31, 6'd63);
		send_beat(OP_UNDEF_B, 5'd0, 5'd31, 6'd0);
		send_beat(OP_FILL, 5'd31, 5'd31, 6'd0);
		// build a chain 0 -> 1 -> 2 -> 3 and check the closure
		repeat (4) send_beat(OP_ADD, 5'd31, 5'd31, 6'd63);
		send_beat(OP_LINK, 5'd0, 5'd1, 6'd0);
		send_beat(OP_LINK, 5'd1, 5'd2, 6'd0);
		send_beat(OP_LINK, 5'd2, 5'd3, 6'd0);
		send_beat(OP_PAIR, 5'd0, 5'd3, 6'd0);
		send_beat(OP_ROW, 5'd0, 5'd31, 6'd0);
		// unlink leaves derived paths in place
		send_beat(OP_UNLINK, 5'd0, 5'd1, 6'd0);
		send_beat(OP_PAIR, 5'd0, 5'd1, 6'd0);
		send_beat(OP_LINK, 5'd3, 5'd0, 6'd0);
		send_beat(OP_ROW, 5'd2, 5'd0, 6'd0);
		send_beat(OP_LINK, 5'd4, 5'd0, 6'd0);
		send_beat(OP_PAIR, 5'd0, 5'd31, 6'd0);
		// fill: shrink, past capacity, then same count
		send_beat(OP_FILL, 5'd0, 5'd0, 6'd3);
		send_beat(OP_FILL, 5'd0, 5'd0, 6'd33);
		send_beat(OP_FILL, 5'd0, 5'd0, 6'd4);
		send_beat(OP_ROW, 5'd3, 5'd0, 6'd0);

		// random traffic over four mixes of input idling and output stall; hold the output off once midway through the first
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_plan[ph];
			stall_pct     = stall_plan[ph];
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 0 && n == ITEMS_PER_PHASE / 2)
					hold_off_req = 1'b1;
				random_beat();
			end
		end

		// full matrix: capacity limits and the top node
		send_beat(OP_FILL, 5'd0, 5'd0, 6'd32);
		send_beat(OP_ADD, 5'd0, 5'd0, 6'd0);
		send_beat(OP_ROW, 5'd31, 5'd0, 6'd0);
		send_beat(OP_UNLINK, 5'd31, 5'd0, 6'd0);
		send_beat(OP_PAIR, 5'd31, 5'd0, 6'd0);
		send_beat(OP_LINK, 5'd0, 5'd31, 6'd0);
		send_beat(OP_ROW, 5'd31, 5'd31, 6'd0);
		send_beat(OP_FILL, 5'd0, 5'd0, 6'd63);
		send_beat(OP_FILL, 5'd0, 5'd0, 6'd32);
		in_valid <= 1'b0;

		// drain, then give any stray beat time to show up
		while (reach_check.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d add, %0d link, %0d unlink, %0d pair, %0d row, %0d fill, %0d undefined.",
			reach_check.beats_by_op[OP_ADD], reach_check.beats_by_op[OP_LINK],
			reach_check.beats_by_op[OP_UNLINK], reach_check.beats_by_op[OP_PAIR],
			reach_check.beats_by_op[OP_ROW], reach_check.beats_by_op[OP_FILL],
			reach_check.beats_by_op[OP_UNDEF_A] + reach_check.beats_by_op[OP_UNDEF_B]);
		$display("%0d rejected, %0d results checked, %0d nodes at the end, one long output hold.",
			reach_check.rejected, reach_check.answers_checked, reach_check.live);
		if (reach_check.mismatches == 0)
			$display("PASS reachability_matrix_closure");
		else
			$display("FAIL reachability_matrix_closure");
		$finish;
	end

endmodule
